// ===== src/sce_pkg.sv =====
// sce_pkg: shared constants, item types and decimal conversion helpers for
// the servo command encoder. No dependencies.
`default_nettype none
package sce_pkg;

  // block configuration defaults
  localparam int NUM_SERVOS_DEF     = 6;
  localparam int REVERSED_SERVO_DEF = 3;
  localparam int NUM_REGS           = 6;
  localparam int ID_W               = 3;
  localparam int ADDR_W             = 5;
  localparam int REV_RESET_IDX      = 3;

  localparam logic [31:0] LIM_DEFAULT   = 32'h00B4_0000;
  localparam logic [31:0] LIM_REV_RESET = 32'h0000_00B4;

  // pulse mapping
  localparam logic [11:0] PULSE_MIN  = 12'd500;
  localparam logic [26:0] PULSE_SPAN = 27'd2000;
  localparam int QW    = 11;
  localparam int NDIV  = (QW + 1) / 2;
  localparam int TSTEP = 3;
  localparam int TBITS = 16;

  // ascii codes
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef struct packed {
    logic            op;
    logic            bad;
    logic [ID_W-1:0] id;
  } sce_ctl_t;

  typedef struct packed {
    sce_ctl_t    ctl;
    logic [15:0] pbcd;
    logic [2:0]  pnd;
    logic [19:0] tbcd;
    logic [2:0]  tnd;
  } sce_item_t;

  // one double-dabble step on five bcd digits over a 16-bit binary value
  function automatic logic [35:0] tdd_step(input logic [35:0] s);
    logic [35:0] r;
    r = s;
    for (int i = 0; i < 5; i++) begin
      if (r[16+4*i +: 4] >= 4'd5) r[16+4*i +: 4] = r[16+4*i +: 4] + 4'd3;
    end
    return {r[34:0], 1'b0};
  endfunction

  // one double-dabble step on four bcd digits over a 12-bit binary value
  function automatic logic [27:0] pdd_step(input logic [27:0] s);
    logic [27:0] r;
    r = s;
    for (int i = 0; i < 4; i++) begin
      if (r[12+4*i +: 4] >= 4'd5) r[12+4*i +: 4] = r[12+4*i +: 4] + 4'd3;
    end
    return {r[26:0], 1'b0};
  endfunction

endpackage
`default_nettype wire

// ===== src/servo_command_encoder_core.sv =====
// servo_command_encoder_core: top level with limit registers, arithmetic
// pipeline and character serializer. Depends on sce_pkg, sce_pipe, sce_ser.
//
// Usage: a request transaction on the in channel (opcode, servo_index,
// target_angle, move_time) produces a run of character transactions on the
// out channel; last_byte_o marks the final character of each command.
// A move emits "#<id>P<pulse>T<time>" CR LF, a stop emits "STOP <n>" CR for
// every channel, an out-of-range id emits one zero character with
// bad_servo_o set. Limits are written over the APB port at 4*index.
// Path: an accepted request passes the ten-stage arithmetic pipeline (clamp,
// multiply, six divider stages of up to two quotient bits, two bcd stages),
// then the serializer's command and output registers, before its first
// character is presented.
// Throughput: one character per cycle while the receiver is ready; a command
// has 1 to 7*NUM_SERVOS characters. New requests enter the pipeline every
// cycle while earlier ones are printed, until the pipeline backs up.
// Reset clears all valid state and loads the limit defaults. When the
// receiver stalls, the output register holds its character and the stall
// backs up through the pipeline without loss.
`default_nettype none
module servo_command_encoder_core #(
  parameter int NUM_SERVOS     = sce_pkg::NUM_SERVOS_DEF,
  parameter int REVERSED_SERVO = sce_pkg::REVERSED_SERVO_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire logic [sce_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              opcode_i,
  input  wire logic [15:0]                 servo_index_i,
  input  wire logic signed [15:0]          target_angle_i,
  input  wire logic [15:0]                 move_time_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [7:0]                       tx_byte_o,
  output logic                             last_byte_o,
  output logic                             bad_servo_o
);

  logic [31:0] lim_q [sce_pkg::NUM_REGS];
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sce_pkg::NUM_REGS; i++) begin
        lim_q[i] <= (i == sce_pkg::REV_RESET_IDX) ? sce_pkg::LIM_REV_RESET
                                                  : sce_pkg::LIM_DEFAULT;
      end
    end else if (psel && penable && pwrite && pready &&
                 (ridx < 3'(sce_pkg::NUM_REGS))) begin
      lim_q[ridx] <= pwdata;
    end
  end

  // register read back
  always_comb begin
    prdata = 32'h0;
    if (ridx < 3'(sce_pkg::NUM_REGS)) prdata = lim_q[ridx];
  end

  // limits of the addressed servo
  logic [sce_pkg::ID_W-1:0] id;
  logic [31:0]              lim;
  sce_pkg::sce_ctl_t        ctl;
  always_comb begin
    id  = servo_index_i[sce_pkg::ID_W-1:0];
    lim = sce_pkg::LIM_DEFAULT;
    if (id < 3'(sce_pkg::NUM_REGS)) lim = lim_q[id];
    ctl.op  = opcode_i;
    ctl.bad = !opcode_i && (servo_index_i >= 16'(NUM_SERVOS));
    ctl.id  = id;
  end

  logic               p_valid, p_ready;
  sce_pkg::sce_item_t p_item;

  sce_pipe #(
    .REVERSED_SERVO(REVERSED_SERVO)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_ctl_i    (ctl),
    .angle_i     (target_angle_i),
    .time_i      (move_time_i),
    .lim_i       (lim),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_item_o  (p_item)
  );

  sce_ser #(
    .NUM_SERVOS(NUM_SERVOS)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .item_i      (p_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o),
    .bad_servo_o (bad_servo_o)
  );

endmodule
`default_nettype wire

// ===== src/sce_pipe.sv =====
// sce_pipe: clamp, scale, restoring divide and bcd conversion pipeline.
// Depends on sce_pkg.
`default_nettype none
module sce_pipe #(
  parameter int REVERSED_SERVO = sce_pkg::REVERSED_SERVO_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire sce_pkg::sce_ctl_t     in_ctl_i,
  input  wire logic signed [15:0]    angle_i,
  input  wire logic [15:0]           time_i,
  input  wire logic [31:0]           lim_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output sce_pkg::sce_item_t         out_item_o
);

  localparam int ND = sce_pkg::NDIV;
  localparam logic [sce_pkg::ID_W-1:0] ID_REV = sce_pkg::ID_W'(REVERSED_SERVO);

  // stage a: clamped difference and span
  logic                va_q;
  sce_pkg::sce_ctl_t   ca_q;
  logic signed [16:0]  diff_q, span_q;
  logic [15:0]         ta_q;

  // stage b is index 0, divider stages are 1..ND
  logic              v_q [ND+1];
  sce_pkg::sce_ctl_t c_q [ND+1];
  logic              z_q [ND+1];
  logic [26:0]       r_q [ND+1];
  logic [15:0]       d_q [ND+1];
  logic [10:0]       q_q [ND+1];
  logic [35:0]       t_q [ND+1];

  // pulse conversion stages
  logic              vp0_q, vp1_q;
  sce_pkg::sce_ctl_t cp0_q;
  logic [27:0]       pp0_q;
  logic [19:0]       tp0_q;
  sce_pkg::sce_item_t item_q;

  logic       rdy_a;
  logic       rdy [ND+1];
  logic       rdy_p0, rdy_p1;

  // ready chain from the output back
  always_comb begin
    rdy_p1 = !vp1_q | out_ready_i;
    rdy_p0 = !vp0_q | rdy_p1;
    rdy[ND] = !v_q[ND] | rdy_p0;
    for (int k = ND - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] | rdy[k+1];
    end
    rdy_a = !va_q | rdy[0];
  end

  assign in_ready_o = rdy_a;

  // clamp to the servo limits
  logic signed [15:0] lf, ls, lx;
  logic               rev;
  always_comb begin
    lf  = signed'(lim_i[15:0]);
    ls  = signed'(lim_i[31:16]);
    lx  = angle_i;
    rev = (in_ctl_i.id == ID_REV);
    if (rev) begin
      if (lf < lx) lx = lf;
      else if (ls > lx) lx = ls;
    end else begin
      if (lf > lx) lx = lf;
      else if (ls < lx) lx = ls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      ca_q   <= in_ctl_i;
      diff_q <= {lx[15], lx} - {lf[15], lf};
      span_q <= {ls[15], ls} - {lf[15], lf};
      ta_q   <= time_i;
    end
  end

  // stage b: magnitudes and numerator product
  logic [16:0] ad_full, as_full;
  logic [26:0] num;
  always_comb begin
    ad_full = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
    as_full = span_q[16] ? 17'(-span_q) : 17'(span_q);
    num     = 27'(ad_full[15:0]) * sce_pkg::PULSE_SPAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && va_q) begin
      c_q[0] <= ca_q;
      z_q[0] <= (span_q == 17'sd0);
      r_q[0] <= num;
      d_q[0] <= as_full[15:0];
      q_q[0] <= '0;
      t_q[0] <= {20'b0, ta_q};
    end
  end

  // divider stages: up to two quotient bits and up to three time bcd steps each
  logic [26:0] rn [ND];
  logic [10:0] qn [ND];
  logic [35:0] tn [ND];
  always_comb begin
    logic [26:0] r;
    logic [26:0] sh;
    logic [10:0] q;
    logic [35:0] t;
    int          kb;
    for (int j = 0; j < ND; j++) begin
      r = r_q[j];
      q = q_q[j];
      t = t_q[j];
      for (int s = 0; s < 2; s++) begin
        kb = sce_pkg::QW - 1 - 2 * j - s;
        if (kb >= 0) begin
          sh = {11'b0, d_q[j]} << kb;
          if (r >= sh) begin
            r     = r - sh;
            q[kb] = 1'b1;
          end
        end
      end
      for (int s = 0; s < sce_pkg::TSTEP; s++) begin
        if (sce_pkg::TSTEP * j + s < sce_pkg::TBITS) t = sce_pkg::tdd_step(t);
      end
      rn[j] = r;
      qn[j] = q;
      tn[j] = t;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (rdy[j+1]) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j+1] && v_q[j]) begin
        c_q[j+1] <= c_q[j];
        z_q[j+1] <= z_q[j];
        r_q[j+1] <= rn[j];
        d_q[j+1] <= d_q[j];
        q_q[j+1] <= qn[j];
        t_q[j+1] <= tn[j];
      end
    end
  end

  // pulse offset and the two halves of its bcd conversion
  logic [11:0] pulse;
  logic [27:0] p0n, p1n;
  always_comb begin
    pulse = z_q[ND] ? sce_pkg::PULSE_MIN : ({1'b0, q_q[ND]} + sce_pkg::PULSE_MIN);
    p0n   = {16'b0, pulse};
    for (int s = 0; s < 6; s++) p0n = sce_pkg::pdd_step(p0n);
    p1n = pp0_q;
    for (int s = 0; s < 6; s++) p1n = sce_pkg::pdd_step(p1n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp0_q <= 1'b0;
      vp1_q <= 1'b0;
    end else begin
      if (rdy_p0) vp0_q <= v_q[ND];
      if (rdy_p1) vp1_q <= vp0_q;
    end
  end

  // digit counts for unpadded printing
  logic [2:0] tnd;
  always_comb begin
    if (tp0_q[19:16] != 4'd0) tnd = 3'd5;
    else if (tp0_q[15:12] != 4'd0) tnd = 3'd4;
    else if (tp0_q[11:8] != 4'd0) tnd = 3'd3;
    else if (tp0_q[7:4] != 4'd0) tnd = 3'd2;
    else tnd = 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p0 && v_q[ND]) begin
      cp0_q <= c_q[ND];
      pp0_q <= p0n;
      tp0_q <= t_q[ND][35:16];
    end
    if (rdy_p1 && vp0_q) begin
      item_q.ctl  <= cp0_q;
      item_q.pbcd <= p1n[27:12];
      item_q.pnd  <= (p1n[27:24] != 4'd0) ? 3'd4 : 3'd3;
      item_q.tbcd <= tp0_q;
      item_q.tnd  <= tnd;
    end
  end

  assign out_valid_o = vp1_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

// ===== src/sce_ser.sv =====
// sce_ser: walks one formatted command and emits its ascii characters
// through an output register. Depends on sce_pkg.
`default_nettype none
module sce_ser #(
  parameter int NUM_SERVOS = sce_pkg::NUM_SERVOS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire sce_pkg::sce_item_t  item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic [7:0]               tx_byte_o,
  output logic                     last_byte_o,
  output logic                     bad_servo_o
);

  localparam logic [3:0] ST_BAD  = 4'd0;
  localparam logic [3:0] ST_HASH = 4'd1;
  localparam logic [3:0] ST_ID   = 4'd2;
  localparam logic [3:0] ST_P    = 4'd3;
  localparam logic [3:0] ST_PUL  = 4'd4;
  localparam logic [3:0] ST_T    = 4'd5;
  localparam logic [3:0] ST_TIM  = 4'd6;
  localparam logic [3:0] ST_CR   = 4'd7;
  localparam logic [3:0] ST_LF   = 4'd8;
  localparam logic [3:0] ST_STOP = 4'd9;

  localparam logic [sce_pkg::ID_W-1:0] LAST_CH = sce_pkg::ID_W'(NUM_SERVOS - 1);

  sce_pkg::sce_item_t itm_q;
  logic               busy_q;
  logic [3:0]         st_q, st_d;
  logic [2:0]         dig_q, dig_d;
  logic [sce_pkg::ID_W-1:0] chan_q, chan_d;
  logic               ov_q, last_q, bad_q;
  logic [7:0]         tx_q;

  logic       adv, load;
  logic [7:0] cur_byte;
  logic       cur_last, cur_bad;
  logic [3:0] pdig, tdig;

  assign adv  = busy_q & (!ov_q | out_ready_i);
  assign pdig = itm_q.pbcd[{dig_q[1:0], 2'b00} +: 4];
  assign tdig = itm_q.tbcd[{dig_q, 2'b00} +: 4];

  // character and next position
  always_comb begin
    cur_byte = 8'h00;
    cur_last = 1'b0;
    cur_bad  = 1'b0;
    st_d     = st_q;
    dig_d    = dig_q;
    chan_d   = chan_q;
    case (st_q)
      ST_BAD: begin
        cur_last = 1'b1;
        cur_bad  = 1'b1;
      end
      ST_HASH: begin
        cur_byte = sce_pkg::CH_HASH;
        st_d     = ST_ID;
      end
      ST_ID: begin
        cur_byte = sce_pkg::CH_ZERO | 8'(itm_q.ctl.id);
        st_d     = ST_P;
      end
      ST_P: begin
        cur_byte = sce_pkg::CH_P;
        st_d     = ST_PUL;
        dig_d    = itm_q.pnd - 3'd1;
      end
      ST_PUL: begin
        cur_byte = sce_pkg::CH_ZERO | {4'b0, pdig};
        if (dig_q == 3'd0) st_d = ST_T;
        else dig_d = dig_q - 3'd1;
      end
      ST_T: begin
        cur_byte = sce_pkg::CH_T;
        st_d     = ST_TIM;
        dig_d    = itm_q.tnd - 3'd1;
      end
      ST_TIM: begin
        cur_byte = sce_pkg::CH_ZERO | {4'b0, tdig};
        if (dig_q == 3'd0) st_d = ST_CR;
        else dig_d = dig_q - 3'd1;
      end
      ST_CR: begin
        cur_byte = sce_pkg::CH_CR;
        if (!itm_q.ctl.op) begin
          st_d = ST_LF;
        end else begin
          cur_last = (chan_q == LAST_CH);
          st_d     = ST_STOP;
          dig_d    = 3'd0;
          chan_d   = chan_q + 1'b1;
        end
      end
      ST_LF: begin
        cur_byte = sce_pkg::CH_LF;
        cur_last = 1'b1;
      end
      ST_STOP: begin
        case (dig_q)
          3'd0:    cur_byte = sce_pkg::CH_S;
          3'd1:    cur_byte = sce_pkg::CH_T;
          3'd2:    cur_byte = sce_pkg::CH_O;
          3'd3:    cur_byte = sce_pkg::CH_P;
          3'd4:    cur_byte = sce_pkg::CH_SP;
          default: cur_byte = sce_pkg::CH_ZERO | 8'(chan_q);
        endcase
        if (dig_q == 3'd5) st_d = ST_CR;
        else dig_d = dig_q + 3'd1;
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase
  end

  assign in_ready_o = !busy_q | (adv & cur_last);
  assign load       = in_valid_i & in_ready_o;

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      st_q   <= ST_BAD;
      dig_q  <= 3'd0;
      chan_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        st_q   <= item_i.ctl.op ? ST_STOP : (item_i.ctl.bad ? ST_BAD : ST_HASH);
        dig_q  <= 3'd0;
        chan_q <= '0;
      end else if (adv) begin
        if (cur_last) busy_q <= 1'b0;
        st_q   <= st_d;
        dig_q  <= dig_d;
        chan_q <= chan_d;
      end
      if (adv) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // item and output payload
  always_ff @(posedge clk_i) begin
    if (load) itm_q <= item_i;
    if (adv) begin
      tx_q   <= cur_byte;
      last_q <= cur_last;
      bad_q  <= cur_bad;
    end
  end

  assign out_valid_o = ov_q;
  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;
  assign bad_servo_o = bad_q;

  // error transaction is a single zero character
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && bad_q |-> last_q && tx_q == 8'h00)
    else $error("bad servo transaction not a lone zero character");

  // no new character without an item in progress
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> !ov_q || $stable(tx_q))
    else $error("character emitted while idle");

  a_tim_dig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && st_q == ST_TIM |-> dig_q < 3'd5)
    else $error("time digit index out of range");

  a_pul_dig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && st_q == ST_PUL |-> dig_q < 3'd4)
    else $error("pulse digit index out of range");

endmodule
`default_nettype wire

// ===== dv/servo_command_encoder_core_test.sv =====
// servo_command_encoder_core_test: self-checking testbench for the servo
// command encoder. Depends on sce_pkg and servo_command_encoder_core.
`default_nettype none
module servo_command_encoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSERVO = sce_pkg::NUM_SERVOS_DEF;
  localparam int REVSRV = sce_pkg::REVERSED_SERVO_DEF;

  typedef enum logic {OP_MOVE = 1'b0, OP_STOP = 1'b1} op_e;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic       bad;
  } char_t;

  // command text predictor and store of expected characters
  class cmd_text_board;
    logic [31:0] limits[8];
    char_t       pending[$];
    int          errors;

    function void reset_limits();
      for (int i = 0; i < 8; i++) limits[i] = sce_pkg::LIM_DEFAULT;
      limits[sce_pkg::REV_RESET_IDX] = sce_pkg::LIM_REV_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void push_char(logic [7:0] c);
      char_t e;
      e.tx = c; e.last = 1'b0; e.bad = 1'b0;
      pending.push_back(e);
    endfunction

    function void push_dec(int unsigned v);
      logic [7:0] d[10];
      int k;
      k = 0;
      do begin
        d[k] = sce_pkg::CH_ZERO + 8'(v % 10);
        v = v / 10;
        k++;
      end while (v != 0);
      while (k > 0) begin
        k--;
        push_char(d[k]);
      end
    endfunction

    function int unsigned pulse_of(int id, logic signed [15:0] ang);
      longint lo, hi, x, span;
      lo = longint'($signed(limits[id][15:0]));
      hi = longint'($signed(limits[id][31:16]));
      x = longint'(ang);
      if (id == REVSRV) begin
        if (lo < x) x = lo;
        else if (hi > x) x = hi;
      end else begin
        if (lo > x) x = lo;
        else if (hi < x) x = hi;
      end
      span = hi - lo;
      if (span == 0) return 500;
      return int'((x - lo) * 2000 / span + 500);
    endfunction

    // note one accepted request
    function void note_request(op_e op, logic [15:0] id, logic signed [15:0] ang,
                               logic [15:0] tm);
      char_t e;
      if (op == OP_STOP) begin
        for (int i = 0; i < NSERVO; i++) begin
          push_char(sce_pkg::CH_S); push_char(sce_pkg::CH_T);
          push_char(sce_pkg::CH_O); push_char(sce_pkg::CH_P);
          push_char(sce_pkg::CH_SP); push_dec(i); push_char(sce_pkg::CH_CR);
        end
      end else if (id >= NSERVO) begin
        e.tx = 8'h00; e.last = 1'b1; e.bad = 1'b1;
        pending.push_back(e);
        return;
      end else begin
        push_char(sce_pkg::CH_HASH); push_dec(id); push_char(sce_pkg::CH_P);
        push_dec(pulse_of(id, ang)); push_char(sce_pkg::CH_T); push_dec(tm);
        push_char(sce_pkg::CH_CR); push_char(sce_pkg::CH_LF);
      end
      pending[$].last = 1'b1;
    endfunction

    // compare one accepted character with the oldest expectation
    function void check_char(char_t got);
      char_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected character tx=%h last=%b bad=%b",
                 $time, got.tx, got.last, got.bad);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.tx !== want.tx) begin
        $display("%0t: tx_byte expected %h actual %h", $time, want.tx, got.tx);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.bad !== want.bad) begin
        $display("%0t: bad_servo expected %b actual %b", $time, want.bad, got.bad);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [sce_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o, opcode_i;
  logic [15:0] servo_index_i, move_time_i;
  logic signed [15:0] target_angle_i;
  logic out_valid_o, out_ready_i;
  logic [7:0] tx_byte_o;
  logic last_byte_o, bad_servo_o;

  cmd_text_board board;
  bit calm;

  servo_command_encoder_core u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .opcode_i, .servo_index_i, .target_angle_i,
    .move_time_i, .out_valid_o, .out_ready_i, .tx_byte_o, .last_byte_o,
    .bad_servo_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20ms;
    $display("servo_command_encoder_core_test failed");
    $finish;
  end

  // receiver: random stalls, sample at rising edge
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= calm || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_char('{tx: tx_byte_o, last: last_byte_o, bad: bad_servo_o});
  end

  task automatic reg_write(int idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= sce_pkg::ADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < sce_pkg::NUM_REGS) board.limits[idx] = val;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // valid stays high into the next request unless an idle gap is drawn
  task automatic send_request(op_e op, logic [15:0] id, logic signed [15:0] ang,
                              logic [15:0] tm);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; opcode_i <= op; servo_index_i <= id;
    target_angle_i <= ang; move_time_i <= tm;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, id, ang, tm);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_request();
    int r;
    logic [15:0] id;
    r = $urandom_range(99);
    if (r < 8) id = 16'($urandom);
    else id = 16'($urandom_range(NSERVO - 1));
    if (r < 4) send_request(OP_STOP, 16'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 60)
      send_request(OP_MOVE, id, 16'($signed($urandom_range(400)) - 100), 16'($urandom));
    else send_request(OP_MOVE, id, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    board = new();
    board.reset_limits();
    calm = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; opcode_i = 1'b0; servo_index_i = '0;
    target_angle_i = '0; move_time_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: defaults, extremes, stop, bad ids
    send_request(OP_MOVE, 16'd0, 16'sd90, 16'd0);
    send_request(OP_MOVE, 16'd1, -16'sd32768, 16'd65535);
    send_request(OP_MOVE, 16'd2, 16'sd32767, 16'd1000);
    send_request(OP_MOVE, 16'd3, 16'sd45, 16'd9);
    send_request(OP_MOVE, 16'd3, 16'sd32767, 16'd10);
    send_request(OP_MOVE, 16'd3, -16'sd32768, 16'd99);
    send_request(OP_MOVE, 16'd5, 16'sd180, 16'd12345);
    send_request(OP_MOVE, 16'd6, 16'sd0, 16'd0);
    send_request(OP_MOVE, 16'hFFFF, -16'sd1, 16'hFFFF);
    send_request(OP_STOP, 16'hFFFF, -16'sd1, 16'hFFFF);
    send_request(OP_STOP, 16'd0, 16'sd0, 16'd0);
    wait_drained();

    // equal limits, crossed limits, full range limits
    reg_write(0, 32'h0064_0064);
    reg_write(1, 32'h0000_00B4);
    reg_write(2, 32'h7FFF_8000);
    reg_write(3, 32'h8000_7FFF);
    reg_write(4, 32'hFFFF_FFFF);
    reg_write(5, 32'h8000_7FFF);
    for (int i = 0; i < NSERVO; i++) begin
      send_request(OP_MOVE, 16'(i), 16'sd32767, 16'd7);
      send_request(OP_MOVE, 16'(i), -16'sd32768, 16'd70);
      send_request(OP_MOVE, 16'(i), 16'sd50, 16'd700);
    end
    wait_drained();

    // random phases with changing limits
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < sce_pkg::NUM_REGS; i++) begin
        if (ph == 5)
          reg_write(i, (i == REVSRV) ? sce_pkg::LIM_REV_RESET : sce_pkg::LIM_DEFAULT);
        else reg_write(i, $urandom);
      end
      calm = (ph == 2);
      for (int n = 0; n < 45; n++) begin
        random_request();
        if (n == 20) wait_drained();
      end
      wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("servo_command_encoder_core_test passed");
    else
      $display("servo_command_encoder_core_test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
src/sce_pkg.sv
src/sce_pipe.sv
src/sce_ser.sv
src/servo_command_encoder_core.sv
dv/servo_command_encoder_core_test.sv
